/* sv/cluster_cone_midpoint_macros.svh */
// assertion macros shared by the cone midpoint rtl
`ifndef CLUSTER_CONE_MIDPOINT_MACROS_SVH
`define CLUSTER_CONE_MIDPOINT_MACROS_SVH

// clocked check, masked while reset is asserted
`define CCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also runs during reset
`define CCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/ccm_pkg.sv */
// shared types and constants for the cluster cone midpoint block
package ccm_pkg;

    // configuration register geometry
    localparam int REG_W     = 15;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SEED    = 3'd4;

    // configuration reset values
    localparam logic [REG_W-1:0] RST_MIN_HEIGHT  = 15'd100;
    localparam logic [REG_W-1:0] RST_MAX_HEIGHT  = 15'd400;
    localparam logic [REG_W-1:0] RST_MAX_WIDTH_X = 15'd300;
    localparam logic [REG_W-1:0] RST_MAX_WIDTH_Y = 15'd300;
    localparam logic [REG_W-1:0] RST_BOX_SEED    = 15'd10000;

    // half-plane rank of a bearing
    typedef enum logic [1:0] {
        BC_LOW  = 2'd0,
        BC_MID  = 2'd1,
        BC_HIGH = 2'd2
    } bearing_class_t;

endpackage

/* sv/cluster_cone_midpoint.sv */
// cluster cone midpoint finder: per-cluster box, two top-bearing points, midpoint out
//
// channel   dir  transfer when         payload
// s_*       in   s_tvalid & s_tready   tdata: x, y, z; tuser: first of frame; tlast: last of cluster
// m_*       out  m_tvalid & m_tready   tdata: mid x, mid y, frame low z
// cfg_wr_*  in   cfg_wr_en             index, 15-bit value, no read-back
//
// one point per cycle sustained while the result register is empty or being drained; a point
//   lands in the input register, and from there the bearing compare (four parallel products)
//   and box update run into state and the result register, which then shows the result
// the running cluster state is a single feedback loop, which sets the one-point rate
// reset clears the handshake, cluster-open and frame state and loads config defaults
// a stalled result holds the input register; the input side keeps taking transfers
//   as long as the result register is empty or being drained
`include "cluster_cone_midpoint_macros.svh"

module cluster_cone_midpoint #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // config write port
    input  logic                                       cfg_wr_en,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]              cfg_wr_index,
    input  logic [ccm_pkg::REG_W-1:0]                  cfg_wr_data,
    // point stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,  // point_x, point_y, point_z
    input  logic                                       s_tuser,  // first_of_frame
    input  logic                                       s_tlast,  // last_of_cluster
    // midpoint stream
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_tdata   // mid_x, mid_y, mid_z
);
    import ccm_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int DATA_W = ((3*COORD_WIDTH+7)/8)*8;
    // box width must hold the seed as well as a coordinate
    localparam int BW     = (COORD_WIDTH > REG_W + 1) ? COORD_WIDTH : REG_W + 1;

    // config registers
    logic [REG_W-1:0] min_height_reg, max_height_reg;
    logic [REG_W-1:0] max_width_x_reg, max_width_y_reg;
    logic [REG_W-1:0] box_seed_reg;

    // input register
    logic                in_valid_reg;
    logic signed [W-1:0] in_x_reg, in_y_reg, in_z_reg;
    logic                in_first_reg, in_last_reg;

    // cluster state
    logic                 cluster_open_reg, cluster_open_next;
    logic signed [BW-1:0] box_min_x_reg, box_max_x_reg, box_min_x_next, box_max_x_next;
    logic signed [BW-1:0] box_min_y_reg, box_max_y_reg, box_min_y_next, box_max_y_next;
    logic signed [BW-1:0] box_min_z_reg, box_max_z_reg, box_min_z_next, box_max_z_next;
    logic signed [W-1:0]  best0_x_reg, best0_y_reg, best0_x_next, best0_y_next;
    logic signed [W-1:0]  best1_x_reg, best1_y_reg, best1_x_next, best1_y_next;
    logic                 best0_valid_reg, best1_valid_reg, best0_valid_next, best1_valid_next;
    logic signed [W-1:0]  cluster_low_reg, cluster_low_next;
    logic signed [W-1:0]  frame_low_reg, frame_low_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic signed [W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [W-1:0] out_x_next, out_y_next;

    logic process;

    // a point in the input register moves on when the result slot is free
    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_z_reg, out_y_reg, out_x_reg});

    function automatic bearing_class_t bclass(input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] y);
        bearing_class_t c;
        if (y[W-1])
            c = BC_LOW;
        else if ((y == '0) && !x[W-1])
            c = BC_MID;
        else
            c = BC_HIGH;
        return c;
    endfunction

    // true when bearing of a is strictly above bearing of b
    function automatic logic bearing_above(input logic signed [W-1:0] ax,
                                           input logic signed [W-1:0] ay,
                                           input logic signed [W-1:0] bx,
                                           input logic signed [W-1:0] by);
        bearing_class_t   ca, cb;
        logic signed [2*W-1:0] p, q;
        logic r;
        ca = bclass(ax, ay);
        cb = bclass(bx, by);
        p  = bx * ay;
        q  = by * ax;
        if (ca != cb)
            r = (ca > cb);
        else if (ca == BC_MID)
            r = 1'b0;
        else
            r = (p > q);
        return r;
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_height_reg  <= RST_MIN_HEIGHT;
            max_height_reg  <= RST_MAX_HEIGHT;
            max_width_x_reg <= RST_MAX_WIDTH_X;
            max_width_y_reg <= RST_MAX_WIDTH_Y;
            box_seed_reg    <= RST_BOX_SEED;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_wr_index)
                CFG_MIN_HEIGHT:  min_height_reg  <= cfg_wr_data;
                CFG_MAX_HEIGHT:  max_height_reg  <= cfg_wr_data;
                CFG_MAX_WIDTH_X: max_width_x_reg <= cfg_wr_data;
                CFG_MAX_WIDTH_Y: max_width_y_reg <= cfg_wr_data;
                CFG_BOX_SEED:    box_seed_reg    <= cfg_wr_data;
                default:         ;  // unmapped index, write dropped
            endcase
        end
    end

    // per-point update
    always_comb
    begin
        logic signed [BW-1:0]  seed_pos, seed_neg;
        logic signed [BW-1:0]  px, py, pz;
        logic signed [BW-1:0]  e_min_x, e_max_x, e_min_y, e_max_y, e_min_z, e_max_z;
        logic                  e_valid0, e_valid1;
        logic signed [W-1:0]   e_cluster_low, e_frame_low;
        logic                  above0, above1;
        logic signed [BW:0]    h, wx, wy;
        logic                  qualify;
        logic signed [W-1:0]   x2, y2;
        logic signed [W:0]     sum_x, sum_y;

        seed_pos = BW'(signed'({1'b0, box_seed_reg}));
        seed_neg = -seed_pos;
        px = BW'(in_x_reg);
        py = BW'(in_y_reg);
        pz = BW'(in_z_reg);

        // a closed cluster reopens from the seed on its first point
        e_min_x       = cluster_open_reg ? box_min_x_reg : seed_pos;
        e_max_x       = cluster_open_reg ? box_max_x_reg : seed_neg;
        e_min_y       = cluster_open_reg ? box_min_y_reg : seed_pos;
        e_max_y       = cluster_open_reg ? box_max_y_reg : seed_neg;
        e_min_z       = cluster_open_reg ? box_min_z_reg : seed_pos;
        e_max_z       = cluster_open_reg ? box_max_z_reg : seed_neg;
        e_valid0      = cluster_open_reg && best0_valid_reg;
        e_valid1      = cluster_open_reg && best1_valid_reg;
        e_cluster_low = cluster_open_reg ? cluster_low_reg : '0;
        e_frame_low   = in_first_reg ? '0 : frame_low_reg;

        box_min_x_next   = (px < e_min_x) ? px : e_min_x;
        box_max_x_next   = (px > e_max_x) ? px : e_max_x;
        box_min_y_next   = (py < e_min_y) ? py : e_min_y;
        box_max_y_next   = (py > e_max_y) ? py : e_max_y;
        box_min_z_next   = (pz < e_min_z) ? pz : e_min_z;
        box_max_z_next   = (pz > e_max_z) ? pz : e_max_z;
        cluster_low_next = (in_z_reg < e_cluster_low) ? in_z_reg : e_cluster_low;

        // top-two bearing insert, ties keep the earlier point
        above0 = bearing_above(in_x_reg, in_y_reg, best0_x_reg, best0_y_reg);
        above1 = bearing_above(in_x_reg, in_y_reg, best1_x_reg, best1_y_reg);
        best0_x_next     = best0_x_reg;
        best0_y_next     = best0_y_reg;
        best1_x_next     = best1_x_reg;
        best1_y_next     = best1_y_reg;
        best0_valid_next = e_valid0;
        best1_valid_next = e_valid1;
        if (!e_valid0)
        begin
            best0_x_next     = in_x_reg;
            best0_y_next     = in_y_reg;
            best0_valid_next = 1'b1;
        end
        else if (above0)
        begin
            best1_x_next     = best0_x_reg;
            best1_y_next     = best0_y_reg;
            best1_valid_next = 1'b1;
            best0_x_next     = in_x_reg;
            best0_y_next     = in_y_reg;
        end
        else if (!e_valid1 || above1)
        begin
            best1_x_next     = in_x_reg;
            best1_y_next     = in_y_reg;
            best1_valid_next = 1'b1;
        end

        // size check on the closing point
        h  = (BW+1)'(box_max_z_next) - (BW+1)'(box_min_z_next);
        wx = (BW+1)'(box_max_x_next) - (BW+1)'(box_min_x_next);
        wy = (BW+1)'(box_max_y_next) - (BW+1)'(box_min_y_next);
        qualify = in_last_reg
               && (h  > (BW+1)'(signed'({1'b0, min_height_reg})))
               && (h  < (BW+1)'(signed'({1'b0, max_height_reg})))
               && (wx < (BW+1)'(signed'({1'b0, max_width_x_reg})))
               && (wy < (BW+1)'(signed'({1'b0, max_width_y_reg})));

        // a lone point stands for both best points
        x2 = best1_valid_next ? best1_x_next : best0_x_next;
        y2 = best1_valid_next ? best1_y_next : best0_y_next;
        sum_x = (W+1)'(best0_x_next) + (W+1)'(x2);
        sum_y = (W+1)'(best0_y_next) + (W+1)'(y2);
        out_x_next = sum_x[W:1];  // arithmetic halving floors
        out_y_next = sum_y[W:1];

        frame_low_next = e_frame_low;
        if (qualify && (cluster_low_next < e_frame_low))
            frame_low_next = cluster_low_next;

        cluster_open_next = !in_last_reg;

        if (process)
            out_valid_next = qualify;
        else
            out_valid_next = out_valid_reg && !m_tready;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_x_reg     <= s_tdata[W-1:0];
            in_y_reg     <= s_tdata[2*W-1:W];
            in_z_reg     <= s_tdata[3*W-1:2*W];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // cluster and frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_open_reg <= 1'b0;
            best0_valid_reg  <= 1'b0;
            best1_valid_reg  <= 1'b0;
            cluster_low_reg  <= '0;
            frame_low_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                cluster_open_reg <= cluster_open_next;
                best0_valid_reg  <= best0_valid_next;
                best1_valid_reg  <= best1_valid_next;
                cluster_low_reg  <= cluster_low_next;
                frame_low_reg    <= frame_low_next;
            end
        end
    end

    // box, best points and result payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            box_min_x_reg <= box_min_x_next;
            box_max_x_reg <= box_max_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_y_reg <= box_max_y_next;
            box_min_z_reg <= box_min_z_next;
            box_max_z_reg <= box_max_z_next;
            best0_x_reg   <= best0_x_next;
            best0_y_reg   <= best0_y_next;
            best1_x_reg   <= best1_x_next;
            best1_y_reg   <= best1_y_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= frame_low_next;
        end
    end

    // checks
    `CCM_ASSERT(a_stall_only_on_full_result, !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready), "input stalled without a blocked result")
    `CCM_ASSERT(a_box_ordered, cluster_open_reg |-> (box_max_x_reg >= box_min_x_reg && box_max_y_reg >= box_min_y_reg), "open cluster box inverted")
    `CCM_ASSERT(a_second_needs_first, best1_valid_reg |-> best0_valid_reg, "second best point without a first")
    `CCM_ASSERT(a_result_z_nonpositive, out_valid_reg |-> (out_z_reg[W-1] || out_z_reg == '0), "result z above zero")
    `CCM_ASSERT(a_frame_low_nonpositive, frame_low_reg[W-1] || frame_low_reg == '0, "frame low z above zero")

endmodule

/* tb/cluster_cone_midpoint_checker.sv */
// checker for the cone midpoint block: tracks config, predicts midpoints, compares transfers
module cluster_cone_midpoint_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]              cfg_wr_index,
    input  logic [ccm_pkg::REG_W-1:0]                  cfg_wr_data,
    input  logic                                       s_tvalid,
    input  logic                                       s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,  // point_x, point_y, point_z
    input  logic                                       s_tuser,  // first_of_frame
    input  logic                                       s_tlast,  // last_of_cluster
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_tdata,  // mid_x, mid_y, mid_z
    output int                                         fail_count,
    output int                                         midpoints_due,
    output int                                         midpoints_checked
);
    import ccm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    // mid_x, mid_y, mid_z from the lowest bit up, as on m_tdata
    typedef logic [3*COORD_WIDTH-1:0] midpoint_t;

    string field_name [3] = '{"mid_x", "mid_y", "mid_z"};

    longint height_floor, height_ceil, width_x_cap, width_y_cap, seed_mm;
    longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    longint lead_x, lead_y, runner_x, runner_y;
    longint cluster_floor_z, frame_floor_z;
    longint span_x, span_y, span_z, mate_x, mate_y;
    bit     lead_ok, runner_ok, open_flag;
    coord_t pt_x, pt_y, pt_z;
    midpoint_t got, want;
    midpoint_t midpoint_q[$];
    int     mismatches = 0;
    int     checked = 0;

    function automatic bearing_class_t rank_of(input longint x, input longint y);
        if (y < 0)
            return BC_LOW;
        if (y == 0 && x >= 0)
            return BC_MID;
        return BC_HIGH;
    endfunction

    // bearing of a strictly above bearing of b
    function automatic bit turns_past(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        bearing_class_t ra, rb;
        ra = rank_of(ax, ay);
        rb = rank_of(bx, by);
        if (ra != rb)
            return ra > rb;
        if (ra == BC_MID)
            return 1'b0;
        return bx * ay > by * ax;
    endfunction

    task start_cluster();
        lo_x = seed_mm;
        hi_x = -seed_mm;
        lo_y = seed_mm;
        hi_y = -seed_mm;
        lo_z = seed_mm;
        hi_z = -seed_mm;
        lead_ok = 1'b0;
        runner_ok = 1'b0;
        lead_x = 0;
        lead_y = 0;
        runner_x = 0;
        runner_y = 0;
        cluster_floor_z = 0;
        open_flag = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_floor = RST_MIN_HEIGHT;
            height_ceil  = RST_MAX_HEIGHT;
            width_x_cap  = RST_MAX_WIDTH_X;
            width_y_cap  = RST_MAX_WIDTH_Y;
            seed_mm      = RST_BOX_SEED;
            start_cluster();
            open_flag = 1'b0;
            frame_floor_z = 0;
            midpoint_q.delete();
        end
        else
        begin
            // result side first: nothing can come out in the cycle its point goes in
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[3*COORD_WIDTH-1:0];
                if (midpoint_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected midpoint transfer x=%0d y=%0d z=%0d",
                                 $signed(got[0 +: COORD_WIDTH]),
                                 $signed(got[COORD_WIDTH +: COORD_WIDTH]),
                                 $signed(got[2*COORD_WIDTH +: COORD_WIDTH]));
                end
                else
                begin
                    want = midpoint_q.pop_front();
                    checked++;
                    for (int f = 0; f < 3; f++)
                    begin
                        if (got[f*COORD_WIDTH +: COORD_WIDTH] !== want[f*COORD_WIDTH +: COORD_WIDTH])
                        begin
                            mismatches++;
                            if (mismatches <= REPORT_LIMIT)
                                $display("midpoint %0d %s: expected %0d, got %0d", checked,
                                         field_name[f],
                                         $signed(want[f*COORD_WIDTH +: COORD_WIDTH]),
                                         $signed(got[f*COORD_WIDTH +: COORD_WIDTH]));
                        end
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_wr_index)
                    CFG_MIN_HEIGHT:  height_floor = cfg_wr_data;
                    CFG_MAX_HEIGHT:  height_ceil  = cfg_wr_data;
                    CFG_MAX_WIDTH_X: width_x_cap  = cfg_wr_data;
                    CFG_MAX_WIDTH_Y: width_y_cap  = cfg_wr_data;
                    CFG_BOX_SEED:    seed_mm      = cfg_wr_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                pt_x = s_tdata[0 +: COORD_WIDTH];
                pt_y = s_tdata[COORD_WIDTH +: COORD_WIDTH];
                pt_z = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];

                if (s_tuser)
                    frame_floor_z = 0;
                if (!open_flag)
                    start_cluster();

                if (pt_x < lo_x) lo_x = pt_x;
                if (pt_x > hi_x) hi_x = pt_x;
                if (pt_y < lo_y) lo_y = pt_y;
                if (pt_y > hi_y) hi_y = pt_y;
                if (pt_z < lo_z) lo_z = pt_z;
                if (pt_z > hi_z) hi_z = pt_z;
                if (pt_z < cluster_floor_z) cluster_floor_z = pt_z;

                // keep the two top bearings, earlier point wins a tie
                if (!lead_ok)
                begin
                    lead_x = pt_x;
                    lead_y = pt_y;
                    lead_ok = 1'b1;
                end
                else if (turns_past(pt_x, pt_y, lead_x, lead_y))
                begin
                    runner_x = lead_x;
                    runner_y = lead_y;
                    runner_ok = 1'b1;
                    lead_x = pt_x;
                    lead_y = pt_y;
                end
                else if (!runner_ok || turns_past(pt_x, pt_y, runner_x, runner_y))
                begin
                    runner_x = pt_x;
                    runner_y = pt_y;
                    runner_ok = 1'b1;
                end

                if (s_tlast)
                begin
                    span_z = hi_z - lo_z;
                    span_x = hi_x - lo_x;
                    span_y = hi_y - lo_y;
                    if (span_z > height_floor && span_z < height_ceil &&
                        span_x < width_x_cap && span_y < width_y_cap)
                    begin
                        // a lone point stands in for the missing second one
                        mate_x = runner_ok ? runner_x : lead_x;
                        mate_y = runner_ok ? runner_y : lead_y;
                        if (cluster_floor_z < frame_floor_z)
                            frame_floor_z = cluster_floor_z;
                        want[0 +: COORD_WIDTH]             = (lead_x + mate_x) >>> 1;
                        want[COORD_WIDTH +: COORD_WIDTH]   = (lead_y + mate_y) >>> 1;
                        want[2*COORD_WIDTH +: COORD_WIDTH] = frame_floor_z;
                        midpoint_q.insert(midpoint_q.size(), want);
                    end
                    open_flag = 1'b0;
                end
            end
        end
        fail_count        <= mismatches;
        midpoints_due     <= midpoint_q.size();
        midpoints_checked <= checked;
    end

endmodule

/* tb/cluster_cone_midpoint_tb.sv */
// testbench top for the cone midpoint block: stimulus, handshake pacing and verdict
module cluster_cone_midpoint_tb;
    import ccm_pkg::*;

    localparam int COORD_WIDTH  = 16;
    localparam int TDATA_W      = ((3*COORD_WIDTH+7)/8)*8;
    localparam int CLK_PERIOD   = 8;
    // a result passes the input and result registers after its closing point; leave a margin
    localparam int DRAIN_CYCLES = 8;
    // hard time limit for the whole run, set well above the slowest run
    localparam int LIMIT_TIME   = 400000 * CLK_PERIOD;
    localparam int NUM_PHASES   = 8;
    localparam int COORD_MAX    = 32767;
    localparam int COORD_MIN    = -32768;
    localparam int REG_MAX      = 32767;
    // register indexes past the last one; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [REG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;   // point_x, point_y, point_z
    logic                 s_tuser = 1'b0; // first_of_frame
    logic                 s_tlast = 1'b0; // last_of_cluster
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;        // mid_x, mid_y, mid_z

    int fail_total;
    int expected_left;
    int midpoints_seen;

    // stimulus-side copy of the current limits, only used to shape clusters
    int cur_min_h = RST_MIN_HEIGHT;
    int cur_max_h = RST_MAX_HEIGHT;
    int cur_wx    = RST_MAX_WIDTH_X;
    int cur_wy    = RST_MAX_WIDTH_Y;
    int cur_seed  = RST_BOX_SEED;

    int burst_left = 0;
    int points_sent = 0;
    int settings_used = 1;

    // receiver stall pattern state
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;

    always #(CLK_PERIOD/2) clk = ~clk;

    cluster_cone_midpoint #(
        .COORD_WIDTH (COORD_WIDTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    cluster_cone_midpoint_checker #(
        .COORD_WIDTH (COORD_WIDTH)
    ) scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_index      (cfg_wr_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_total),
        .midpoints_due     (expected_left),
        .midpoints_checked (midpoints_seen)
    );

    // receiver: alternates between always ready, coin-flip ready and long stalls
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 200);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    rx_stall_left = $urandom_range(3, 20);
                end
            end
        endcase
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(LIMIT_TIME);
        $display("timeout: run did not finish, %0d midpoints still due", expected_left);
        $display("FAIL cluster_cone_midpoint");
        $finish;
    end

    function automatic coord_t fit16(input int v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    function automatic int span_cap(input int v);
        if (v < 0)
            return 0;
        if (v > 1500)
            return 1500;
        return v;
    endfunction

    // one point transfer; the sender runs in bursts with random gaps between them
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                              input logic fof, input logic loc);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
        s_tdata  <= {pz, py, px};
        s_tuser  <= fof;
        s_tlast  <= loc;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        points_sent++;
    endtask

    // stop sending and wait until every predicted midpoint has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value[REG_W-1:0];
        @(posedge clk);
    endtask

    // writes every register while idle, plus a junk write to an unused index
    task automatic load_settings(input int min_h, input int max_h, input int wx,
                                 input int wy, input int seed);
        logic [CFG_IDX_W-1:0] spare;
        settle();
        spare = CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        put_reg(CFG_MIN_HEIGHT, min_h);
        put_reg(CFG_MAX_HEIGHT, max_h);
        put_reg(CFG_MAX_WIDTH_X, wx);
        put_reg(CFG_MAX_WIDTH_Y, wy);
        put_reg(spare, $urandom_range(0, REG_MAX));
        put_reg(CFG_BOX_SEED, seed);
        cfg_wr_en <= 1'b0;
        cur_min_h = min_h;
        cur_max_h = max_h;
        cur_wx    = wx;
        cur_wy    = wy;
        cur_seed  = seed;
        settings_used++;
    endtask

    // one cluster: mostly shaped to the current limits, some with an outlier, some noise
    task automatic send_cluster();
        int kind, n, lim, cx, cy, cz, wxt, wyt, ht, px, py, pz, odd_one;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            // loose point with every field random
            send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                       $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
            return;
        end
        n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 7);
        // outlier index past the end means a clean cluster
        odd_one = (kind < 6) ? $urandom_range(0, n - 1) : n;
        wxt = $urandom_range(0, span_cap(cur_wx - 1));
        wyt = $urandom_range(0, span_cap(cur_wy - 1));
        if (cur_max_h - cur_min_h >= 2)
            ht = $urandom_range(cur_min_h + 1, (cur_max_h - 1 < cur_min_h + 2000) ?
                                               cur_max_h - 1 : cur_min_h + 2000);
        else
            ht = $urandom_range(0, 600);
        // keep the box inside the seed so its extent is the real one
        lim = (cur_seed > 30000) ? 30000 : cur_seed;
        if ($urandom_range(0, 3) == 0)
            lim = 100;  // hug the origin to hit the half-plane boundaries
        cx = $urandom_range(0, 2 * lim);
        cx = cx - lim;
        cy = $urandom_range(0, 2 * lim);
        cy = cy - lim;
        cz = $urandom_range(0, 2 * lim);
        cz = cz - lim;
        for (int i = 0; i < n; i++)
        begin
            px = $urandom_range(0, wxt);
            px = px + cx;
            py = $urandom_range(0, wyt);
            py = py + cy;
            if (i == 0)
                pz = cz;
            else if (i == 1)
                pz = cz + ht;
            else
            begin
                pz = $urandom_range(0, ht);
                pz = pz + cz;
            end
            if ($urandom_range(0, 7) == 0)
                py = 0;  // on the bearing zero or pi axis
            if (i == odd_one)
            begin
                px = int'(coord_t'($urandom));
                py = int'(coord_t'($urandom));
                pz = int'(coord_t'($urandom));
            end
            send_point(fit16(px), fit16(py), fit16(pz), $urandom_range(0, 15) == 0,
                       i == n - 1);
        end
    endtask

    initial
    begin
        int budget;
        int phase_points;
        bit paused;
        int mh;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset limits: height in (100, 400), widths below 300
        // all three bearing classes in one cluster
        send_point(100, -5, 0, 1'b1, 1'b0);
        send_point(100, 0, 50, 1'b0, 1'b0);
        send_point(-100, 0, 120, 1'b0, 1'b0);
        send_point(-50, 40, 200, 1'b0, 1'b1);
        // equal bearings: the earlier point is kept
        send_point(50, 50, -30, 1'b0, 1'b0);
        send_point(100, 100, 0, 1'b0, 1'b0);
        send_point(25, 25, 150, 1'b0, 1'b1);
        // origin and positive x axis all share bearing zero
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(5, 0, 10, 1'b0, 1'b0);
        send_point(10, 0, 250, 1'b0, 1'b1);
        // odd negative sum, midpoint rounds down
        send_point(-3, 1, 0, 1'b0, 1'b0);
        send_point(-2, 1, 101, 1'b0, 1'b1);
        // frame mark lands inside an open cluster
        send_point(30, -20, -200, 1'b0, 1'b0);
        send_point(31, -21, -50, 1'b1, 1'b0);
        send_point(40, -25, -100, 1'b0, 1'b1);
        // height exactly at each limit does not qualify
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(0, 1, 100, 1'b0, 1'b1);
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(1, 1, 400, 1'b0, 1'b1);
        // x width at the limit fails, one below passes
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(300, 0, 200, 1'b0, 1'b1);
        send_point(0, 0, 0, 1'b0, 1'b0);
        send_point(299, 0, 200, 1'b0, 1'b1);
        // coordinate extremes as one-point clusters
        send_point(-32768, -32768, -32768, 1'b1, 1'b1);
        send_point(32767, 32767, 32767, 1'b0, 1'b1);

        // zero seed lets a lone point qualify, its midpoint is itself
        load_settings(RST_MIN_HEIGHT, RST_MAX_HEIGHT, RST_MAX_WIDTH_X, RST_MAX_WIDTH_Y, 0);
        send_point(5, -7, 200, 1'b0, 1'b1);
        send_point(-9, 3, 150, 1'b0, 1'b1);

        // random phases over several register settings
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            budget = 280;
            case (phase)
                0: load_settings(RST_MIN_HEIGHT, RST_MAX_HEIGHT, RST_MAX_WIDTH_X,
                                 RST_MAX_WIDTH_Y, RST_BOX_SEED);
                1: load_settings(0, REG_MAX, REG_MAX, REG_MAX, 0);
                2:
                begin
                    // nothing can qualify, keep it short
                    load_settings(0, 0, 0, 0, 0);
                    budget = 120;
                end
                3: load_settings(0, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
                4:
                begin
                    load_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
                    budget = 120;
                end
                default:
                begin
                    mh = $urandom_range(0, 500);
                    load_settings(mh, mh + $urandom_range(2, 1200), $urandom_range(1, 2000),
                                  $urandom_range(1, 2000),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                                              : $urandom_range(0, REG_MAX));
                end
            endcase
            phase_points = points_sent;
            paused = 1'b0;
            while (points_sent - phase_points < budget)
            begin
                // halfway through, hold the sender until the block has drained
                if (!paused && points_sent - phase_points >= budget / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                send_cluster();
            end
        end

        settle();

        $display("run covered %0d points under %0d register settings", points_sent,
                 settings_used);
        $display("%0d midpoints compared, %0d mismatches", midpoints_seen, fail_total);
        if (expected_left != 0)
            $display("%0d predicted midpoints never came out", expected_left);
        if (fail_total == 0 && expected_left == 0)
            $display("PASS cluster_cone_midpoint");
        else
            $display("FAIL cluster_cone_midpoint");
        $finish;
    end

endmodule
